### hdl/sbfh_pkg.sv
package sbfh_pkg;

	localparam int CoordW = 32;
	localparam int DiffW  = CoordW + 1;   // span of two coordinates
	localparam int QuoW   = 17;           // t in Q1.16, 65536 = 1.0
	localparam int ProdW  = DiffW + QuoW + 1;
	localparam int PntW   = CoordW + 4;
	localparam int EpsW   = 16;
	localparam int NumAx  = 3;
	localparam int NumFc  = 6;
	localparam int FaceW  = 3;
	localparam logic [EpsW-1:0] EpsReset = 16'd66;

	typedef struct packed {
		logic signed [CoordW-1:0] seg_start_x;
		logic signed [CoordW-1:0] seg_start_y;
		logic signed [CoordW-1:0] seg_start_z;
		logic signed [CoordW-1:0] seg_end_x;
		logic signed [CoordW-1:0] seg_end_y;
		logic signed [CoordW-1:0] seg_end_z;
		logic signed [CoordW-1:0] box_min_x;
		logic signed [CoordW-1:0] box_min_y;
		logic signed [CoordW-1:0] box_min_z;
		logic signed [CoordW-1:0] box_max_x;
		logic signed [CoordW-1:0] box_max_y;
		logic signed [CoordW-1:0] box_max_z;
	} in_t;

	typedef struct packed {
		logic             hit;
		logic [QuoW-1:0]  hit_param;
		logic [FaceW-1:0] hit_face;
	} out_t;

	// per-item data riding alongside the dividers
	typedef struct packed {
		logic                                  vld;
		logic [NumFc-1:0]                      keep;
		logic [NumAx-1:0][DiffW-1:0]           dif;
		logic [NumAx-1:0][CoordW-1:0]          st;
		logic [NumAx-1:0][CoordW-1:0]          lo;
		logic [NumAx-1:0][CoordW-1:0]          hi;
	} side_t;

endpackage

### hdl/sbfh_div.sv
// Pipelined restoring divider, one quotient bit per stage.
// Requires num <= den; quo = floor(num * 2^16 / den).
module sbfh_div import sbfh_pkg::*; (
	input  logic             clk,
	input  logic [DiffW-1:0] num,
	input  logic [DiffW-1:0] den,
	output logic [QuoW-1:0]  quo
);

	logic [DiffW-1:0] rem_s [QuoW];
	logic [DiffW-1:0] den_s [QuoW];
	logic [QuoW-1:0]  quo_s [QuoW];

	always_ff @(posedge clk) begin
		if (num >= den) begin
			rem_s[0] <= num - den;
			quo_s[0] <= {{(QuoW-1){1'b0}}, 1'b1};
		end else begin
			rem_s[0] <= num;
			quo_s[0] <= '0;
		end
		den_s[0] <= den;
	end

	for (genvar i = 1; i < QuoW; i++) begin : g_step
		logic [DiffW:0] sh;
		logic [DiffW:0] sub;
		logic           ge;
		assign sh  = {rem_s[i-1], 1'b0};
		assign ge  = sh >= {1'b0, den_s[i-1]};
		assign sub = sh - {1'b0, den_s[i-1]};
		always_ff @(posedge clk) begin
			rem_s[i] <= ge ? sub[DiffW-1:0] : sh[DiffW-1:0];
			quo_s[i] <= {quo_s[i-1][QuoW-2:0], ge};
			den_s[i] <= den_s[i-1];
		end
	end

	assign quo = quo_s[QuoW-1];

endmodule

### hdl/segment_box_first_hit.sv
// Channel   | Ports                      | Notes
// ----------+----------------------------+-------------------------------------
// input     | start, busy, item_in       | taken when start && !busy
// result    | done, result               | one-cycle strobe, one result per item
// config    | cfg_we, cfg_wdata          | parallel threshold, written when idle
//
// One item per cycle. Stages: 1 setup stage, 17 divider stages
// (one quotient bit each), 1 multiply, 1 point test, 1 face select.
// busy is held low; the pipe never stalls since the receiver cannot.
// arst_n clears the valid bits and sets the threshold to 66.
module segment_box_first_hit import sbfh_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  in_t             item_in,
	output logic            done,
	output out_t            result,
	input  logic            cfg_we,
	input  logic [EpsW-1:0] cfg_wdata
);

	logic [EpsW-1:0] eps_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q <= EpsReset;
		end else if (cfg_we) begin
			eps_q <= cfg_wdata;
		end
	end

	assign busy = 1'b0;

	// ---- stage 1: spans, plane offsets, keep flags ----
	logic [NumAx-1:0][CoordW-1:0] st_c, en_c, lo_c, hi_c;
	assign st_c = {item_in.seg_start_z, item_in.seg_start_y, item_in.seg_start_x};
	assign en_c = {item_in.seg_end_z, item_in.seg_end_y, item_in.seg_end_x};
	assign lo_c = {item_in.box_min_z, item_in.box_min_y, item_in.box_min_x};
	assign hi_c = {item_in.box_max_z, item_in.box_max_y, item_in.box_max_x};

	logic [NumAx-1:0][DiffW-1:0] dif_c, ad_c;
	logic [NumFc-1:0][DiffW-1:0] an_c;
	logic [NumFc-1:0]            keep_c;

	always_comb begin
		logic signed [DiffW-1:0] d, n;
		for (int a = 0; a < NumAx; a++) begin
			d = $signed({en_c[a][CoordW-1], en_c[a]}) - $signed({st_c[a][CoordW-1], st_c[a]});
			dif_c[a] = d;
			ad_c[a]  = d[DiffW-1] ? -d : d;
		end
		for (int f = 0; f < NumFc; f++) begin
			d = $signed(dif_c[f/2]);
			if (f % 2 == 1) begin
				n = $signed({hi_c[f/2][CoordW-1], hi_c[f/2]}) -
					$signed({st_c[f/2][CoordW-1], st_c[f/2]});
			end else begin
				n = $signed({lo_c[f/2][CoordW-1], lo_c[f/2]}) -
					$signed({st_c[f/2][CoordW-1], st_c[f/2]});
			end
			an_c[f] = n[DiffW-1] ? -n : n;
			if (d > 0) begin
				keep_c[f] = (n >= 0) && (n <= d);
			end else begin
				keep_c[f] = (n <= 0) && (n >= d);
			end
			keep_c[f] = keep_c[f] && (ad_c[f/2] > {{(DiffW-EpsW){1'b0}}, eps_q});
		end
	end

	side_t                       side_s1;
	logic [NumFc-1:0][DiffW-1:0] an_s1;
	logic [NumAx-1:0][DiffW-1:0] ad_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			side_s1.vld <= 1'b0;
		end else begin
			side_s1.vld  <= start && !busy;
			side_s1.keep <= keep_c;
			side_s1.dif  <= dif_c;
			side_s1.st   <= st_c;
			side_s1.lo   <= lo_c;
			side_s1.hi   <= hi_c;
		end
	end

	always_ff @(posedge clk) begin
		an_s1        <= an_c;
		ad_s1        <= ad_c;
	end

	// ---- stage 2: dividers, side data delayed to match ----
	logic [NumFc-1:0][QuoW-1:0] tq_c;

	for (genvar f = 0; f < NumFc; f++) begin : g_div
		sbfh_div u_div (
			.clk (clk),
			.num (an_s1[f]),
			.den (ad_s1[f/2]),
			.quo (tq_c[f])
		);
	end

	side_t side_s2 [QuoW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < QuoW; i++) side_s2[i].vld <= 1'b0;
		end else begin
			side_s2[0] <= side_s1;
			for (int i = 1; i < QuoW; i++) side_s2[i] <= side_s2[i-1];
		end
	end

	side_t last_c;
	assign last_c = side_s2[QuoW-1];

	// ---- stage 3: d * t for every face and axis ----
	logic                                    vld_s3;
	logic [NumFc-1:0]                        keep_s3;
	logic [NumFc-1:0][QuoW-1:0]              tq_s3;
	logic [NumFc-1:0][NumAx-1:0][ProdW-1:0]  prod_s3;
	logic [NumAx-1:0][CoordW-1:0]            st_s3, lo_s3, hi_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= last_c.vld;
		end
	end

	always_ff @(posedge clk) begin
		keep_s3 <= last_c.keep;
		tq_s3   <= tq_c;
		st_s3   <= last_c.st;
		lo_s3   <= last_c.lo;
		hi_s3   <= last_c.hi;
		for (int f = 0; f < NumFc; f++) begin
			for (int a = 0; a < NumAx; a++) begin
				prod_s3[f][a] <= ProdW'($signed(last_c.dif[a]) * $signed({1'b0, tq_c[f]}));
			end
		end
	end

	// ---- stage 4: crossing point inside the box ----
	logic             vld_s4;
	logic [NumFc-1:0] ok_s4;
	logic [NumFc-1:0][QuoW-1:0] tq_s4;
	logic [NumFc-1:0] in_c;

	always_comb begin
		logic signed [PntW-1:0] p;
		for (int f = 0; f < NumFc; f++) begin
			in_c[f] = keep_s3[f];
			for (int a = 0; a < NumAx; a++) begin
				// arithmetic shift is the floor of the Q16 product
				p = PntW'($signed(st_s3[a])) +
					PntW'($signed(prod_s3[f][a]) >>> 16);
				if (p < PntW'($signed(lo_s3[a])) || p > PntW'($signed(hi_s3[a]))) begin
					in_c[f] = 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		ok_s4 <= in_c;
		tq_s4 <= tq_s3;
	end

	// ---- stage 5: smallest t, ties to lower face ----
	out_t sel_c;

	always_comb begin
		sel_c = '0;
		for (int f = 0; f < NumFc; f++) begin
			if (ok_s4[f] && (!sel_c.hit || tq_s4[f] < sel_c.hit_param)) begin
				sel_c.hit       = 1'b1;
				sel_c.hit_param = tq_s4[f];
				sel_c.hit_face  = FaceW'(f);
			end
		end
	end

	logic done_s5;
	out_t res_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s5 <= 1'b0;
		end else begin
			done_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		res_s5 <= sel_c;
	end

	assign done   = done_s5;
	assign result = res_s5;

	a_miss_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && !result.hit) |-> (result.hit_param == '0 && result.hit_face == '0))
		else $error("miss with nonzero fields");

	a_hit_range: assert property (@(posedge clk) disable iff (!arst_n)
		(done && result.hit) |-> (result.hit_face <= 3'd5 && result.hit_param <= 17'd65536))
		else $error("hit fields out of range");

	a_hit_kept: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s4 |=> (!result.hit || $past(ok_s4) != '0))
		else $error("hit without a kept face");

	a_done_follow: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |=> ##1 done)
		else $error("item lost between multiply and output");

endmodule
